/* design/mrap_pkg.sv */
// Shared types, widths and helpers for the multi-resource admission packer.
`default_nettype none
package mrap_pkg;

  localparam int RES_W   = 48;            // resource cost / total width
  localparam int PCT_W   = 7;             // percentage register width
  localparam int CNT_W   = 16;            // attempt counter width
  localparam int SCL_W   = RES_W + PCT_W; // width of value*100 and limit*pct
  localparam int NRES    = 3;             // disk, network, compute
  localparam int CIDX_W  = 3;
  localparam int DEC_W   = 3;

  localparam logic [PCT_W-1:0] LOWER_PCT_RST = PCT_W'(75);
  localparam logic [PCT_W-1:0] UPPER_PCT_RST = PCT_W'(90);
  localparam logic [SCL_W:0]   FILL_BIAS     = (SCL_W+1)'(99);

  typedef enum logic [DEC_W-1:0] {
    DEC_ADMIT    = 3'd0,
    DEC_ZERO_FEE = 3'd1,
    DEC_OVER     = 3'd2,
    DEC_CAP      = 3'd3,
    DEC_FILL     = 3'd4
  } decision_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DISK_LIMIT    = 3'd0,
    CFG_NETWORK_LIMIT = 3'd1,
    CFG_COMPUTE_LIMIT = 3'd2,
    CFG_LOWER_PCT     = 3'd3,
    CFG_UPPER_PCT     = 3'd4,
    CFG_MAX_ATTEMPTS  = 3'd5
  } cfg_idx_t;

  // Bounds as products: total >= floor(L*p/100) <=> 100*total + 99 >= L*p,
  // total <= floor(L*p/100) <=> 100*total <= L*p.
  typedef struct packed {
    logic [NRES-1:0][SCL_W-1:0] low_prod;
    logic [NRES-1:0][SCL_W-1:0] up_prod;
    logic [CNT_W-1:0]           max_attempts;
  } thr_t;

  typedef struct packed {
    logic [NRES-1:0][RES_W-1:0] sum;
    logic [NRES-1:0][SCL_W-1:0] sum100;   // 100 * sum, kept alongside
    logic [CNT_W-1:0]           count;
    logic                       stopped;
  } pack_state_t;

  typedef struct packed {
    logic                       start_block;
    logic                       fee_limit_zero;
    logic [NRES-1:0][RES_W-1:0] used;
    logic [NRES-1:0][SCL_W-1:0] used100;
  } item_t;

  function automatic logic [SCL_W-1:0] times100(input logic [RES_W-1:0] x);
    logic [SCL_W-1:0] xe;
    xe = SCL_W'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

endpackage
`default_nettype wire

/* design/mrap_cfg.sv */
// Configuration registers and registered limit*percentage products.
`default_nettype none
module mrap_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [mrap_pkg::CIDX_W-1:0] wr_index,
  input  wire logic [mrap_pkg::RES_W-1:0]  wr_data,
  output mrap_pkg::thr_t                   thr,
  output logic                             settle
);

  logic [mrap_pkg::NRES-1:0][mrap_pkg::RES_W-1:0] limit;
  logic [mrap_pkg::PCT_W-1:0]                     lower_pct;
  logic [mrap_pkg::PCT_W-1:0]                     upper_pct;
  logic [mrap_pkg::CNT_W-1:0]                     max_attempts;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= '0;
      lower_pct    <= mrap_pkg::LOWER_PCT_RST;
      upper_pct    <= mrap_pkg::UPPER_PCT_RST;
      max_attempts <= '0;
    end else if (wr_en) begin
      unique case (mrap_pkg::cfg_idx_t'(wr_index))
        mrap_pkg::CFG_DISK_LIMIT:    limit[0] <= wr_data;
        mrap_pkg::CFG_NETWORK_LIMIT: limit[1] <= wr_data;
        mrap_pkg::CFG_COMPUTE_LIMIT: limit[2] <= wr_data;
        mrap_pkg::CFG_LOWER_PCT:     lower_pct <= wr_data[mrap_pkg::PCT_W-1:0];
        mrap_pkg::CFG_UPPER_PCT:     upper_pct <= wr_data[mrap_pkg::PCT_W-1:0];
        mrap_pkg::CFG_MAX_ATTEMPTS:  max_attempts <= wr_data[mrap_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Products are registered from the config registers; settle flags the cycle after a write, while they still trail it.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= '0;
      settle <= 1'b0;
    end else begin
      for (int i = 0; i < mrap_pkg::NRES; i++) begin
        thr.low_prod[i] <= mrap_pkg::SCL_W'(limit[i]) * mrap_pkg::SCL_W'(lower_pct);
        thr.up_prod[i]  <= mrap_pkg::SCL_W'(limit[i]) * mrap_pkg::SCL_W'(upper_pct);
      end
      thr.max_attempts <= max_attempts;
      settle           <= wr_en;
    end
  end

endmodule
`default_nettype wire

/* design/mrap_step.sv */
// Single-pass admission decision and next packing state for one request.
`default_nettype none
module mrap_step (
  input  wire mrap_pkg::item_t       item,
  input  wire mrap_pkg::pack_state_t cur,
  input  wire mrap_pkg::thr_t        thr,
  output mrap_pkg::pack_state_t      nxt,
  output mrap_pkg::decision_t        decision
);

  mrap_pkg::pack_state_t                                eff;
  logic                                                 cap_hit;
  logic [mrap_pkg::NRES-1:0]                            fill_res;
  logic [mrap_pkg::NRES-1:0]                            fit_res;
  logic [mrap_pkg::NRES-1:0][mrap_pkg::RES_W:0]         new_sum;
  logic [mrap_pkg::NRES-1:0][mrap_pkg::SCL_W:0]         new_100;

  always_comb begin
    eff = item.start_block ? '0 : cur;
    cap_hit = (thr.max_attempts != '0) && (eff.count >= thr.max_attempts);
    for (int i = 0; i < mrap_pkg::NRES; i++) begin
      fill_res[i] = ({1'b0, eff.sum100[i]} + mrap_pkg::FILL_BIAS)
                    >= {1'b0, thr.low_prod[i]};
      new_sum[i]  = {1'b0, eff.sum[i]} + {1'b0, item.used[i]};
      new_100[i]  = {1'b0, eff.sum100[i]} + {1'b0, item.used100[i]};
      // a carry out of the resource width counts as over bound
      fit_res[i]  = !new_sum[i][mrap_pkg::RES_W]
                    && (new_100[i] <= {1'b0, thr.up_prod[i]});
    end

    nxt = eff;
    if (eff.stopped) begin
      decision = cap_hit ? mrap_pkg::DEC_CAP : mrap_pkg::DEC_FILL;
    end else if (cap_hit) begin
      nxt.stopped = 1'b1;
      decision    = mrap_pkg::DEC_CAP;
    end else if (|fill_res) begin
      nxt.stopped = 1'b1;
      decision    = mrap_pkg::DEC_FILL;
    end else begin
      if (eff.count != '1) begin
        nxt.count = eff.count + 1'b1;
      end
      if (item.fee_limit_zero) begin
        decision = mrap_pkg::DEC_ZERO_FEE;
      end else if (&fit_res) begin
        for (int i = 0; i < mrap_pkg::NRES; i++) begin
          nxt.sum[i]    = new_sum[i][mrap_pkg::RES_W-1:0];
          nxt.sum100[i] = new_100[i][mrap_pkg::SCL_W-1:0];
        end
        decision = mrap_pkg::DEC_ADMIT;
      end else begin
        decision = mrap_pkg::DEC_OVER;
      end
    end
  end

endmodule
`default_nettype wire

/* design/multi_resource_admission_packer_core.sv */
// Top level of the multi-resource admission packer: stream ports and pipeline.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_axis   | in        | tvalid / tready    | tdata: disk, network, compute costs;
//           |           |                    | tuser: start_block, fee_limit_zero
//  m_axis   | out       | tvalid / tready    | tdata: disk, network, compute totals;
//           |           |                    | tuser: decision
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// One request per cycle sustained unless m_axis or a config write stalls it (input
// register, then decision logic into the result register, which also updates the sums).
// The single result register sets the rate: it is refilled in the cycle it
// drains, so a stall on m_axis holds the input register and then s_axis.
// Input is held off while a config write is offered and in the cycle after it,
// while the limit*percentage product registers reload.
// Reset (rst, synchronous) clears totals, count, stop flag and both valids.
`default_nettype none
module multi_resource_admission_packer_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,   // [47:0] disk_used, [95:48] network_used,
                                            // [143:96] compute_used
  input  wire logic [1:0]   s_axis_tuser,   // [0] start_block, [1] fee_limit_zero
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // [47:0] disk_total, [95:48] network_total,
                                            // [143:96] compute_total
  output logic [7:0]        m_axis_tuser,   // [2:0] decision, [7:3] zero
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);

  mrap_pkg::thr_t        thr;
  logic                  settle;
  logic                  cfg_wr;

  mrap_pkg::item_t       in_item;
  mrap_pkg::item_t       item_next;
  logic                  in_valid;
  logic                  advance;
  logic                  s_acc;

  mrap_pkg::pack_state_t st;
  mrap_pkg::pack_state_t st_next;
  mrap_pkg::decision_t   dec_next;

  logic                  out_valid;
  mrap_pkg::decision_t   out_dec;
  logic [mrap_pkg::NRES-1:0][mrap_pkg::RES_W-1:0] out_total;

  // Config is always taken; the user must write only while the block is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  mrap_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .thr      (thr),
    .settle   (settle)
  );

  // Advance the input request into the result register when it has room.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = (!in_valid || advance) && !cfg_valid && !settle;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Pre-scale the costs by 100 on the way into the input register.
  always_comb begin
    item_next.start_block    = s_axis_tuser[0];
    item_next.fee_limit_zero = s_axis_tuser[1];
    for (int i = 0; i < mrap_pkg::NRES; i++) begin
      item_next.used[i]    = s_axis_tdata[i*mrap_pkg::RES_W +: mrap_pkg::RES_W];
      item_next.used100[i] =
        mrap_pkg::times100(s_axis_tdata[i*mrap_pkg::RES_W +: mrap_pkg::RES_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_acc) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_item <= item_next;
    end
  end

  mrap_step u_step (
    .item     (in_item),
    .cur      (st),
    .thr      (thr),
    .nxt      (st_next),
    .decision (dec_next)
  );

  // Packing state commits together with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dec   <= dec_next;
      out_total <= st_next.sum;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_total;
  assign m_axis_tuser  = {5'b0, out_dec};

`ifndef SYNTHESIS
  // A stopped run drops every request without a start.
  assert property (@(posedge clk) disable iff (rst)
    (advance && st.stopped && !in_item.start_block) |=>
      (m_axis_tuser[2:0] == mrap_pkg::DEC_CAP || m_axis_tuser[2:0] == mrap_pkg::DEC_FILL))
    else $error("stopped run produced a non-stop decision");

  // Totals only move on an admitted request or a start.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !in_item.start_block && dec_next != mrap_pkg::DEC_ADMIT) |=>
      (st.sum == $past(st.sum)))
    else $error("totals changed without admission");

  // Attempt count never drops within a run.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !in_item.start_block) |=> (st.count >= $past(st.count)))
    else $error("attempt count decreased");

  // No request enters while config is offered or products reload.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid || settle) |-> !s_axis_tready)
    else $error("input taken during config update");
`endif

endmodule
`default_nettype wire
